### src/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared widths, register indexes and transfer types of the triangle
// stiffness block.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int CW    = 32;   // coordinate, Q16.16
    localparam int BW    = 33;   // coordinate difference
    localparam int PXW   = 65;   // x * b product
    localparam int DW    = 66;   // twice the signed area and its magnitude
    localparam int DENW  = 33;   // elastic denominator
    localparam int DDW   = 99;   // denominator times |D|
    localparam int VW    = 100;  // divisor 2 * dd, one bit wider than DDW
    localparam int WTW   = 18;   // elastic weights pp, qq, rr
    localparam int TW    = 66;   // product of two differences
    localparam int HW    = 33;   // half of TW
    localparam int PHW   = 52;   // signed high half times weight
    localparam int PLW   = 51;   // unsigned low half times weight
    localparam int SW    = 86;   // weighted sum
    localparam int MW    = 84;   // magnitude of the weighted sum
    localparam int EW    = 32;   // Young's modulus
    localparam int NUW   = 15;   // Poisson ratio
    localparam int LW    = 28;   // limb of the modulus product
    localparam int LPW   = 60;   // limb times modulus
    localparam int PPW   = 116;  // magnitude times modulus
    localparam int NW    = 148;  // dividend
    localparam int QW    = 64;   // quotient and entry value
    localparam int IW    = 3;    // row and column index
    localparam int CIW   = 2;    // configuration index

    localparam logic [CIW-1:0] CFG_YOUNG   = 2'd0;
    localparam logic [CIW-1:0] CFG_POISSON = 2'd1;
    localparam logic [CIW-1:0] CFG_MODE    = 2'd2;

    localparam logic [IW-1:0] DOF_LAST = 3'd5;

    localparam logic [QW-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [QW-1:0] VAL_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [BW-1:0]  b0;
        logic [BW-1:0]  b1;
        logic [BW-1:0]  b2;
        logic [BW-1:0]  c0;
        logic [BW-1:0]  c1;
        logic [BW-1:0]  c2;
        logic [DDW-1:0] dd;
        logic           degen;
    } item_t;

    typedef struct packed {
        logic [IW-1:0] row;
        logic [IW-1:0] col;
        logic          last;
        logic          degen;
        logic          neg;
    } meta_t;

endpackage

### src/cst_front.sv
// ----------------------------------------------------------------------------
// cst_front
// Per-triangle pipeline: corner differences, twice the signed area, its
// magnitude and the divisor base dd = den * |D|.
// ----------------------------------------------------------------------------
module cst_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [6*cst_pkg::CW-1:0]     in_data,
    input  logic [cst_pkg::DENW-1:0]     den,
    output logic                         out_valid,
    input  logic                         out_take,
    output cst_pkg::item_t               out_item
);

    logic                            adv;
    logic [4:0]                      v_reg;

    logic signed [cst_pkg::CW-1:0]   x_s1_reg [0:2];
    logic signed [cst_pkg::BW-1:0]   b_s1_reg [0:2];
    logic signed [cst_pkg::BW-1:0]   c_s1_reg [0:2];

    logic signed [cst_pkg::PXW-1:0]  p_s2_reg [0:2];
    logic signed [cst_pkg::BW-1:0]   b_s2_reg [0:2];
    logic signed [cst_pkg::BW-1:0]   c_s2_reg [0:2];

    logic [cst_pkg::DW-1:0]          absd_s3_reg;
    logic                            degen_s3_reg;
    logic signed [cst_pkg::BW-1:0]   b_s3_reg [0:2];
    logic signed [cst_pkg::BW-1:0]   c_s3_reg [0:2];

    logic [2*cst_pkg::HW-1:0]        plo_s4_reg;
    logic [2*cst_pkg::HW-1:0]        phi_s4_reg;
    logic                            degen_s4_reg;
    logic signed [cst_pkg::BW-1:0]   b_s4_reg [0:2];
    logic signed [cst_pkg::BW-1:0]   c_s4_reg [0:2];

    cst_pkg::item_t                  item_reg;

    logic signed [cst_pkg::CW-1:0]   xin [0:2];
    logic signed [cst_pkg::CW-1:0]   yin [0:2];
    logic signed [cst_pkg::DW-1:0]   dsum;

    function automatic logic signed [cst_pkg::BW-1:0] sub33
    (
        input logic signed [cst_pkg::CW-1:0] a,
        input logic signed [cst_pkg::CW-1:0] b
    );
        return cst_pkg::BW'(a) - cst_pkg::BW'(b);
    endfunction

    assign adv       = !v_reg[4] || out_take;
    assign in_ready  = adv;
    assign out_valid = v_reg[4];
    assign out_item  = item_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            xin[k] = in_data[2*k*cst_pkg::CW +: cst_pkg::CW];
            yin[k] = in_data[(2*k+1)*cst_pkg::CW +: cst_pkg::CW];
        end
        dsum = cst_pkg::DW'(p_s2_reg[0]) + cst_pkg::DW'(p_s2_reg[1])
             + cst_pkg::DW'(p_s2_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // differences b = y, c = x across the opposite edge
            x_s1_reg <= xin;
            b_s1_reg[0] <= sub33(yin[1], yin[2]);
            b_s1_reg[1] <= sub33(yin[2], yin[0]);
            b_s1_reg[2] <= sub33(yin[0], yin[1]);
            c_s1_reg[0] <= sub33(xin[2], xin[1]);
            c_s1_reg[1] <= sub33(xin[0], xin[2]);
            c_s1_reg[2] <= sub33(xin[1], xin[0]);

            for (int k = 0; k < 3; k++)
            begin
                p_s2_reg[k] <= x_s1_reg[k] * b_s1_reg[k];
            end
            b_s2_reg <= b_s1_reg;
            c_s2_reg <= c_s1_reg;

            absd_s3_reg  <= dsum[cst_pkg::DW-1] ? cst_pkg::DW'(-dsum) : cst_pkg::DW'(dsum);
            degen_s3_reg <= (dsum == '0);
            b_s3_reg     <= b_s2_reg;
            c_s3_reg     <= c_s2_reg;

            plo_s4_reg   <= absd_s3_reg[cst_pkg::HW-1:0] * den;
            phi_s4_reg   <= absd_s3_reg[cst_pkg::DW-1:cst_pkg::HW] * den;
            degen_s4_reg <= degen_s3_reg;
            b_s4_reg     <= b_s3_reg;
            c_s4_reg     <= c_s3_reg;

            item_reg.dd    <= cst_pkg::DDW'({phi_s4_reg, {cst_pkg::HW{1'b0}}})
                            + cst_pkg::DDW'(plo_s4_reg);
            item_reg.degen <= degen_s4_reg;
            item_reg.b0    <= b_s4_reg[0];
            item_reg.b1    <= b_s4_reg[1];
            item_reg.b2    <= b_s4_reg[2];
            item_reg.c0    <= c_s4_reg[0];
            item_reg.c1    <= c_s4_reg[1];
            item_reg.c2    <= c_s4_reg[2];
        end
    end

endmodule

### src/cst_entry.sv
// ----------------------------------------------------------------------------
// cst_entry
// Per-entry product pipeline: weighted sum S of difference products, its
// sign and magnitude, times the modulus, giving dividend N and divisor V.
// ----------------------------------------------------------------------------
module cst_entry
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic signed [cst_pkg::BW-1:0] a1,
    input  logic signed [cst_pkg::BW-1:0] a2,
    input  logic signed [cst_pkg::BW-1:0] a3,
    input  logic signed [cst_pkg::BW-1:0] a4,
    input  logic [cst_pkg::WTW-1:0]       w1,
    input  logic [cst_pkg::WTW-1:0]       w2,
    input  logic [cst_pkg::DDW-1:0]       dd,
    input  cst_pkg::meta_t                meta,
    input  logic [cst_pkg::EW-1:0]        young,
    output logic                          out_valid,
    output logic [cst_pkg::NW-1:0]        num,
    output logic [cst_pkg::VW-1:0]        dvs,
    output cst_pkg::meta_t                out_meta
);

    logic [7:0]                      v_reg;
    cst_pkg::meta_t                  meta_reg [1:8];
    logic [cst_pkg::DDW-1:0]         dd_reg   [1:7];

    logic signed [cst_pkg::TW-1:0]   t1_reg, t2_reg;
    logic [cst_pkg::WTW-1:0]         w1_reg, w2_reg;
    logic signed [cst_pkg::PHW-1:0]  ph1_reg, ph2_reg;
    logic [cst_pkg::PLW-1:0]         pl1_reg, pl2_reg;
    logic signed [cst_pkg::SW-1:0]   m1_reg, m2_reg;
    logic signed [cst_pkg::SW-1:0]   s_reg;
    logic [cst_pkg::MW-1:0]          mag_reg;
    logic [cst_pkg::LPW-1:0]         q0_reg, q1_reg, q2_reg;
    logic [cst_pkg::PPW-1:0]         prod_reg;
    logic [cst_pkg::NW-1:0]          num_reg;
    logic [cst_pkg::VW-1:0]          dvs_reg;

    assign out_valid = v_reg[7];
    assign num       = num_reg;
    assign dvs       = dvs_reg;
    assign out_meta  = meta_reg[8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta_reg[1] <= meta;
            dd_reg[1]   <= dd;
            for (int k = 2; k <= 8; k++)
            begin
                if (k != 5)
                begin
                    meta_reg[k] <= meta_reg[k-1];
                end
            end
            for (int k = 2; k <= 7; k++)
            begin
                dd_reg[k] <= dd_reg[k-1];
            end
            // sign of S becomes known at the fifth stage
            meta_reg[5] <= {meta_reg[4].row, meta_reg[4].col, meta_reg[4].last,
                            meta_reg[4].degen, s_reg[cst_pkg::SW-1]};

            t1_reg <= a1 * a2;
            t2_reg <= a3 * a4;
            w1_reg <= w1;
            w2_reg <= w2;

            ph1_reg <= $signed(t1_reg[cst_pkg::TW-1:cst_pkg::HW]) * $signed({1'b0, w1_reg});
            ph2_reg <= $signed(t2_reg[cst_pkg::TW-1:cst_pkg::HW]) * $signed({1'b0, w2_reg});
            pl1_reg <= t1_reg[cst_pkg::HW-1:0] * w1_reg;
            pl2_reg <= t2_reg[cst_pkg::HW-1:0] * w2_reg;

            m1_reg <= $signed({ph1_reg[cst_pkg::PHW-1], ph1_reg, {cst_pkg::HW{1'b0}}})
                    + $signed({35'b0, pl1_reg});
            m2_reg <= $signed({ph2_reg[cst_pkg::PHW-1], ph2_reg, {cst_pkg::HW{1'b0}}})
                    + $signed({35'b0, pl2_reg});

            s_reg <= m1_reg + m2_reg;

            mag_reg <= s_reg[cst_pkg::SW-1] ? cst_pkg::MW'(-s_reg) : cst_pkg::MW'(s_reg);

            q0_reg <= mag_reg[cst_pkg::LW-1:0] * young;
            q1_reg <= mag_reg[2*cst_pkg::LW-1:cst_pkg::LW] * young;
            q2_reg <= mag_reg[3*cst_pkg::LW-1:2*cst_pkg::LW] * young;

            prod_reg <= cst_pkg::PPW'(q0_reg)
                      + cst_pkg::PPW'({q1_reg, {cst_pkg::LW{1'b0}}})
                      + {q2_reg, {2*cst_pkg::LW{1'b0}}};

            // N = 2 * |S| * E * 2^30 + dd, V = 2 * dd: rounds half away
            num_reg <= cst_pkg::NW'({prod_reg, 31'b0}) + cst_pkg::NW'(dd_reg[7]);
            dvs_reg <= {dd_reg[7], 1'b0};
        end
    end

endmodule

### src/cst_div.sv
// ----------------------------------------------------------------------------
// cst_div
// Pipelined restoring divider, one quotient bit a stage, with overflow
// check, sign restore and saturation into the output register.
// ----------------------------------------------------------------------------
module cst_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic [cst_pkg::NW-1:0]     num,
    input  logic [cst_pkg::VW-1:0]     dvs,
    input  cst_pkg::meta_t             meta,
    output logic                       out_valid,
    output logic [cst_pkg::IW-1:0]     row_index,
    output logic [cst_pkg::IW-1:0]     col_index,
    output logic [cst_pkg::QW-1:0]     entry_value,
    output logic                       degenerate,
    output logic                       last_entry
);

    localparam int QW = cst_pkg::QW;
    localparam int VW = cst_pkg::VW;

    logic                 vld_reg [0:QW];
    logic [VW-1:0]        rem_reg [0:QW];
    logic [QW-1:0]        nq_reg  [0:QW];
    logic [VW-1:0]        div_reg [0:QW];
    logic                 sat_reg [0:QW];
    cst_pkg::meta_t       meta_reg [0:QW];

    logic                 out_valid_reg;
    logic [cst_pkg::IW-1:0] row_reg, col_reg;
    logic [QW-1:0]        value_reg;
    logic                 degen_reg, last_reg;

    logic [QW-1:0]        quo;
    logic [QW-1:0]        value_next;
    cst_pkg::meta_t       fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    // overflow when the quotient would need more than QW bits
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= VW'(num[cst_pkg::NW-1:QW]);
            nq_reg[0]   <= num[QW-1:0];
            div_reg[0]  <= dvs;
            sat_reg[0]  <= (VW'(num[cst_pkg::NW-1:QW]) >= dvs);
            meta_reg[0] <= meta;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [VW:0] rem2;
        logic        ge;

        assign rem2 = {rem_reg[k], nq_reg[k][QW-1]};
        assign ge   = (rem2 >= {1'b0, div_reg[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k+1]  <= ge ? VW'(rem2 - {1'b0, div_reg[k]}) : rem2[VW-1:0];
                nq_reg[k+1]   <= {nq_reg[k][QW-2:0], ge};
                div_reg[k+1]  <= div_reg[k];
                sat_reg[k+1]  <= sat_reg[k];
                meta_reg[k+1] <= meta_reg[k];
            end
        end
    end

    assign quo = nq_reg[QW];
    assign fin = meta_reg[QW];

    always_comb
    begin
        if (fin.degen)
        begin
            value_next = '0;
        end
        else if (sat_reg[QW])
        begin
            value_next = fin.neg ? cst_pkg::VAL_MIN : cst_pkg::VAL_MAX;
        end
        else if (fin.neg)
        begin
            value_next = (quo > cst_pkg::VAL_MIN) ? cst_pkg::VAL_MIN : QW'(-quo);
        end
        else
        begin
            value_next = (quo > cst_pkg::VAL_MAX) ? cst_pkg::VAL_MAX : quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            row_reg   <= fin.row;
            col_reg   <= fin.col;
            value_reg <= value_next;
            degen_reg <= fin.degen;
            last_reg  <= fin.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign row_index   = row_reg;
    assign col_index   = col_reg;
    assign entry_value = value_reg;
    assign degenerate  = degen_reg;
    assign last_entry  = last_reg;

endmodule

### src/cst_triangle_stiffness.sv
// ----------------------------------------------------------------------------
// cst_triangle_stiffness
// Element stiffness of a constant strain triangle: 21 upper-triangle
// entries of Ke = |area| * B^T C B per request, Q48.16, saturated.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                                    handshake
//  --------  ---------  -----------------------------------------  -----------------
//  s_*       in         six corner coordinates, Q16.16             s_tvalid/s_tready
//  m_*       out        row, col, entry value; degenerate; last    m_tvalid/m_tready
//  cfg_*     in         register index and write data              cfg_valid/cfg_ready
//
//  One request yields 21 entries, one per cycle while m_tready does not
//  stall; the entry sequencer takes the next request with the last entry
//  of the current one. Most of the entry path is the 64-stage quotient pipeline.
//  Reset clears all valid bits and loads E = 1000, nu = 19661, plane stress.
//  A stall on m_tready freezes every entry stage; the front stages keep
//  filling until they meet the waiting request, so nothing is lost.
//
module cst_triangle_stiffness
(
    input  logic                          clk,
    input  logic                          rst_n,
    // request: node_x0, node_y0, node_x1, node_y1, node_x2, node_y2 (32 b each)
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [6*cst_pkg::CW-1:0]      s_tdata,
    // entry: row_index[2:0], col_index[5:3], entry_value[69:6], zero fill
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [71:0]                   m_tdata,
    // degenerate
    output logic                          m_tuser,
    // last_entry
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cst_pkg::CIW-1:0]       cfg_index,
    input  logic [31:0]                   cfg_data
);

    // configuration and the elastic constants derived from it
    logic [cst_pkg::EW-1:0]   young_reg;
    logic [cst_pkg::NUW-1:0]  nu_reg;
    logic                     mode_reg;
    logic [cst_pkg::DENW-1:0] den_reg;
    logic [cst_pkg::WTW-1:0]  pp_reg, qq_reg, rr_reg;

    logic [cst_pkg::DENW-1:0] den_next;
    logic [cst_pkg::WTW-1:0]  pp_next, rr_next, nu2;
    logic [29:0]              nsq;
    logic [35:0]              den_strain;

    // front pipeline
    logic                     f_valid;
    cst_pkg::item_t           f_item;

    // entry sequencer
    logic                     adv;
    logic                     sv_reg;
    cst_pkg::item_t           it_reg;
    logic [cst_pkg::IW-1:0]   row_reg, col_reg;
    logic                     seq_last;
    logic                     seq_free;
    logic                     pop;

    logic signed [cst_pkg::BW-1:0] bi, ci, bj, cj;

    // entry stage zero: operands picked for the current row and column
    logic                          e0_valid_reg;
    logic signed [cst_pkg::BW-1:0] a1_reg, a2_reg, a3_reg, a4_reg;
    logic [cst_pkg::WTW-1:0]       w1_reg, w2_reg;
    logic [cst_pkg::DDW-1:0]       dd_reg;
    cst_pkg::meta_t                meta_reg;

    logic                     p_valid;
    logic [cst_pkg::NW-1:0]   p_num;
    logic [cst_pkg::VW-1:0]   p_dvs;
    cst_pkg::meta_t           p_meta;

    logic [cst_pkg::IW-1:0]   o_row, o_col;
    logic [cst_pkg::QW-1:0]   o_value;

    // ---- configuration port, always ready -------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            young_reg <= 32'd1000;
            nu_reg    <= 15'd19661;
            mode_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cst_pkg::CFG_YOUNG:   young_reg <= cfg_data;
                cst_pkg::CFG_POISSON: nu_reg    <= cfg_data[cst_pkg::NUW-1:0];
                cst_pkg::CFG_MODE:    mode_reg  <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // plane stress: den = 1 - nu^2, pp = 2, rr = 1 - nu (all scaled)
    // plane strain: den = (1 + nu)(1 - 2nu), pp = 2 - 2nu, rr = 1 - 2nu
    always_comb
    begin
        nu2        = {2'b0, nu_reg, 1'b0};
        nsq        = nu_reg * nu_reg;
        den_strain = (36'd65536 + 36'(nu_reg)) * (36'd65536 - 36'(nu2));
        if (mode_reg)
        begin
            den_next = cst_pkg::DENW'(den_strain);
            pp_next  = 18'd131072 - nu2;
            rr_next  = 18'd65536 - nu2;
        end
        else
        begin
            den_next = 33'h1_0000_0000 - {3'b0, nsq};
            pp_next  = 18'd131072;
            rr_next  = 18'd65536 - {3'b0, nu_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        pp_reg  <= pp_next;
        qq_reg  <= nu2;
        rr_reg  <= rr_next;
    end

    // ---- per-triangle front end ------------------------------------------
    cst_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .den      (den_reg),
        .out_valid(f_valid),
        .out_take (pop),
        .out_item (f_item)
    );

    // ---- entry sequencer: walks row 0..5, col row..5 -----------------------
    assign adv      = !m_tvalid || m_tready;
    assign seq_last = (row_reg == cst_pkg::DOF_LAST) && (col_reg == cst_pkg::DOF_LAST);
    assign seq_free = !sv_reg || seq_last;
    assign pop      = adv && seq_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= 1'b0;
        end
        else if (adv && seq_free)
        begin
            sv_reg <= f_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (seq_free)
            begin
                it_reg  <= f_item;
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (col_reg == cst_pkg::DOF_LAST)
            begin
                row_reg <= row_reg + 3'd1;
                col_reg <= row_reg + 3'd1;
            end
            else
            begin
                col_reg <= col_reg + 3'd1;
            end
        end
    end

    // pick b and c of the nodes behind the row and the column
    always_comb
    begin
        case (row_reg[2:1])
            2'd0:    begin bi = it_reg.b0; ci = it_reg.c0; end
            2'd1:    begin bi = it_reg.b1; ci = it_reg.c1; end
            default: begin bi = it_reg.b2; ci = it_reg.c2; end
        endcase
        case (col_reg[2:1])
            2'd0:    begin bj = it_reg.b0; cj = it_reg.c0; end
            2'd1:    begin bj = it_reg.b1; cj = it_reg.c1; end
            default: begin bj = it_reg.b2; cj = it_reg.c2; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e0_valid_reg <= sv_reg;
        end
    end

    // S = w1 * (a1 a2) + rr * (a3 a4); x dofs use b, y dofs use c first
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg         <= row_reg[0] ? ci : bi;
            a2_reg         <= col_reg[0] ? cj : bj;
            a3_reg         <= row_reg[0] ? bi : ci;
            a4_reg         <= col_reg[0] ? bj : cj;
            w1_reg         <= (row_reg[0] == col_reg[0]) ? pp_reg : qq_reg;
            w2_reg         <= rr_reg;
            dd_reg         <= it_reg.dd;
            meta_reg.row   <= row_reg;
            meta_reg.col   <= col_reg;
            meta_reg.last  <= seq_last;
            meta_reg.degen <= it_reg.degen;
            meta_reg.neg   <= 1'b0;
        end
    end

    cst_entry u_entry
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (e0_valid_reg),
        .a1       (a1_reg),
        .a2       (a2_reg),
        .a3       (a3_reg),
        .a4       (a4_reg),
        .w1       (w1_reg),
        .w2       (w2_reg),
        .dd       (dd_reg),
        .meta     (meta_reg),
        .young    (young_reg),
        .out_valid(p_valid),
        .num      (p_num),
        .dvs      (p_dvs),
        .out_meta (p_meta)
    );

    cst_div u_div
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (p_valid),
        .num        (p_num),
        .dvs        (p_dvs),
        .meta       (p_meta),
        .out_valid  (m_tvalid),
        .row_index  (o_row),
        .col_index  (o_col),
        .entry_value(o_value),
        .degenerate (m_tuser),
        .last_entry (m_tlast)
    );

    assign m_tdata = {2'b00, o_value, o_col, o_row};

endmodule

### tb/cst_entry_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cst_entry_checker
// Watches the request, entry and register channels of the triangle
// stiffness block, works out the 21 stiffness entries of every accepted
// request in exact wide integer arithmetic and compares each entry.
// ----------------------------------------------------------------------------
module cst_entry_checker
    import cst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [6*CW-1:0]     s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [71:0]         m_tdata,
    input  logic                m_tuser,
    input  logic                m_tlast,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CIW-1:0]      cfg_index,
    input  logic [31:0]         cfg_data,
    output int                  fail_count,
    output int                  entries_pending,
    output int                  entries_seen
);

    typedef struct {
        logic [IW-1:0] row;
        logic [IW-1:0] col;
        logic [QW-1:0] value;
        logic          degen;
        logic          last;
    } stiff_entry_t;

    stiff_entry_t   stiff_q[$];

    logic [EW-1:0]  young;
    logic [NUW-1:0] poisson;
    logic           strain_mode;

    function automatic logic [255:0] sext32(input logic [31:0] v);
        logic signed [255:0] r;
        r = $signed(v);
        return r;
    endfunction

    // Exact Ke entry: E * 2^30 * S / (den * |D|), rounded half away from zero
    task automatic predict_stiffness(input logic [6*CW-1:0] corners);
        logic [255:0] x[3], y[3], b[3], c[3];
        logic [255:0] d, abs_d, nu, den, pp, qq, rr, dd, scale;
        logic [255:0] t1, t2, w1, w2, s, mag, q;
        logic [QW-1:0] m, val;
        logic degen, neg;
        int row, col, i, j, k;
        stiff_entry_t e;
        for (k = 0; k < 3; k++)
        begin
            x[k] = sext32(corners[k*64 +: 32]);
            y[k] = sext32(corners[k*64+32 +: 32]);
        end
        b[0] = y[1] - y[2]; b[1] = y[2] - y[0]; b[2] = y[0] - y[1];
        c[0] = x[2] - x[1]; c[1] = x[0] - x[2]; c[2] = x[1] - x[0];
        d = x[0]*b[0] + x[1]*b[1] + x[2]*b[2];
        degen = (d == '0);
        abs_d = d[255] ? -d : d;
        nu = poisson;
        if (!strain_mode)
        begin
            den = 256'h1_0000_0000 - nu*nu;
            pp = 131072; qq = 2*nu; rr = 65536 - nu;
        end
        else
        begin
            den = (65536 + nu) * (65536 - 2*nu);
            pp = 131072 - 2*nu; qq = 2*nu; rr = 65536 - 2*nu;
        end
        dd = den * abs_d;
        scale = 256'(young) << 30;
        k = 0;
        for (row = 0; row < 6; row++)
        begin
            for (col = row; col < 6; col++)
            begin
                val = '0;
                if (!degen)
                begin
                    i = row >> 1;
                    j = col >> 1;
                    if (!row[0] && !col[0])
                    begin
                        t1 = b[i]*b[j]; t2 = c[i]*c[j]; w1 = pp; w2 = rr;
                    end
                    else if (!row[0])
                    begin
                        t1 = b[i]*c[j]; t2 = c[i]*b[j]; w1 = qq; w2 = rr;
                    end
                    else if (!col[0])
                    begin
                        t1 = c[i]*b[j]; t2 = b[i]*c[j]; w1 = qq; w2 = rr;
                    end
                    else
                    begin
                        t1 = c[i]*c[j]; t2 = b[i]*b[j]; w1 = pp; w2 = rr;
                    end
                    s = (t1*w1 + t2*w2) * scale;
                    neg = s[255];
                    mag = neg ? -s : s;
                    q = (2*mag + dd) / (2*dd);
                    m = q[63:0];
                    if (q[255:64] != '0)
                        val = neg ? VAL_MIN : VAL_MAX;
                    else if (neg)
                        val = (m > VAL_MIN) ? VAL_MIN : -m;
                    else
                        val = (m > VAL_MAX) ? VAL_MAX : m;
                end
                e.row   = IW'(row);
                e.col   = IW'(col);
                e.value = val;
                e.degen = degen;
                e.last  = (k == 20);
                stiff_q.push_back(e);
                k++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stiff_entry_t exp_e;
        if (!rst_n)
        begin
            young       <= 32'd1000;
            poisson     <= 15'd19661;
            strain_mode <= 1'b0;
            fail_count  = 0;
            entries_seen = 0;
            stiff_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_YOUNG:   young       <= cfg_data;
                    CFG_POISSON: poisson     <= cfg_data[NUW-1:0];
                    CFG_MODE:    strain_mode <= cfg_data[0];
                    default:     ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_stiffness(s_tdata);
            if (m_tvalid && m_tready)
            begin
                entries_seen++;
                if (stiff_q.size() == 0)
                begin
                    $error("entry with nothing expected: row %0d col %0d",
                           m_tdata[2:0], m_tdata[5:3]);
                    fail_count++;
                end
                else
                begin
                    exp_e = stiff_q.pop_front();
                    if (m_tdata[2:0] !== exp_e.row)
                    begin
                        $error("row_index: expected %0d, got %0d", exp_e.row, m_tdata[2:0]);
                        fail_count++;
                    end
                    if (m_tdata[5:3] !== exp_e.col)
                    begin
                        $error("col_index: expected %0d, got %0d", exp_e.col, m_tdata[5:3]);
                        fail_count++;
                    end
                    if (m_tdata[69:6] !== exp_e.value)
                    begin
                        $error("entry_value: expected %h, got %h", exp_e.value, m_tdata[69:6]);
                        fail_count++;
                    end
                    if (m_tuser !== exp_e.degen)
                    begin
                        $error("degenerate: expected %b, got %b", exp_e.degen, m_tuser);
                        fail_count++;
                    end
                    if (m_tlast !== exp_e.last)
                    begin
                        $error("last_entry: expected %b, got %b", exp_e.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        entries_pending = stiff_q.size();
    end

endmodule

### tb/tb_cst_triangle_stiffness.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cst_triangle_stiffness
// Drives corner triangles and register writes into the stiffness block,
// throttles both channels, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_cst_triangle_stiffness;
    import cst_pkg::*;

    localparam int IDLE_LIMIT  = 20000;  // cycles with no transfer at all
    localparam int SETTLE_WAIT = 150;    // more than the entry pipeline latency

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [6*CW-1:0]    s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [71:0]        m_tdata;
    logic               m_tuser;
    logic               m_tlast;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CIW-1:0]     cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    int fail_count;
    int entries_pending;
    int entries_seen;
    int req_count = 0;
    int degen_count = 0;
    int tx_idle_pct = 0;   // chance in a hundred that the sender holds off
    int rx_idle_pct = 0;   // chance in a hundred that the receiver stalls
    int idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cst_triangle_stiffness i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // node_x0, node_y0, node_x1, node_y1, node_x2, node_y2
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // row_index, col_index, entry_value, zero fill
        .m_tuser   (m_tuser),     // degenerate
        .m_tlast   (m_tlast),     // last_entry
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cst_entry_checker i_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .entries_pending (entries_pending),
        .entries_seen    (entries_seen)
    );

    // Receiver throttle: stall at random, or never once the last phase starts
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    // Watchdog: give up once the channels have been silent for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [6*CW-1:0] corners(input logic [31:0] x0, y0, x1, y1, x2, y2);
        return {y2, x2, y1, x1, y0, x0};
    endfunction

    // Issue one request; hold valid until the block takes it
    task automatic send_triangle(input logic [6*CW-1:0] tri_data);
        int gap;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tri_data;
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        req_count++;
        if (tri_data[63:32] == tri_data[127:96] && tri_data[31:0] == tri_data[95:64])
            degen_count++;
    endtask

    // Drain all entries, then let the pipeline settle before a register write
    task automatic drain_block();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (entries_pending == 0);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIW-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_elastic(input logic [31:0] e, input logic [31:0] nu,
                                input logic [31:0] mode);
        drain_block();
        write_reg(CFG_YOUNG, e);
        write_reg(CFG_POISSON, nu);
        write_reg(CFG_MODE, mode);
    endtask

    // Random triangle: mostly modest coordinates, some full range, some collinear
    function automatic logic [6*CW-1:0] random_triangle();
        logic signed [31:0] p[6];
        logic signed [31:0] dx, dy;
        int kind, k;
        kind = $urandom_range(99);
        for (k = 0; k < 6; k++)
            p[k] = $signed($urandom) >>> $urandom_range(8, 14);
        if (kind < 15)
        begin
            for (k = 0; k < 6; k++)
                p[k] = $urandom;
        end
        else if (kind < 25)
        begin
            // collinear corners, either a repeated corner or a straight line
            dx = $signed($urandom) >>> 16;
            dy = $signed($urandom) >>> 16;
            p[2] = p[0] + dx;      p[3] = p[1] + dy;
            p[4] = p[0] + 2 * dx;  p[5] = p[1] + 2 * dy;
            if ($urandom_range(1))
            begin
                p[2] = p[0];
                p[3] = p[1];
            end
        end
        else if (kind < 30)
        begin
            // tiny triangles near one corner
            p[2] = p[0] + $urandom_range(0, 3);
            p[3] = p[1];
            p[4] = p[0];
            p[5] = p[1] + $urandom_range(1, 3);
        end
        return corners(p[0], p[1], p[2], p[3], p[4], p[5]);
    endfunction

    task automatic random_phase(input int count, input bit hold_midway);
        int n;
        for (n = 0; n < count; n++)
        begin
            send_triangle(random_triangle());
            // hold off once until every entry is back
            if (hold_midway && n == count / 2)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                wait (entries_pending == 0);
                @(posedge clk);
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset elastic constants, shapes and orientations
        send_triangle(corners(0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000));
        send_triangle(corners(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0));
        send_triangle(corners(0, 0, 0, 0, 0, 0));
        send_triangle(corners(32'h0001_0000, 32'h0002_0000, 32'h0002_0000,
                              32'h0004_0000, 32'h0003_0000, 32'h0006_0000));
        send_triangle(corners(0, 0, 1, 0, 0, 1));
        send_triangle(corners(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        send_triangle(corners(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        send_triangle(corners(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF,
                              32'h5555_5555, 32'hAAAA_AAAA));

        // Directed: stiffest material, plane strain, Poisson ratio at its top
        load_elastic(32'hFFFF_FFFF, 32'd32767, 32'd1);
        send_triangle(corners(0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000));
        send_triangle(corners(0, 0, 1, 0, 0, 1));
        send_triangle(corners(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        send_triangle(corners(0, 0, 32'h0010_0000, 32'h0010_0000, 32'h0020_0000, 32'h0020_0000));

        // Directed: no stiffness at all, zero Poisson ratio, plane stress
        load_elastic(32'd0, 32'd0, 32'd0);
        send_triangle(corners(0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000));
        send_triangle(corners(0, 0, 0, 0, 0, 0));

        // Directed: unit modulus, zero Poisson ratio, plane strain
        load_elastic(32'd1, 32'd0, 32'd1);
        send_triangle(corners(0, 0, 32'h0003_0000, 0, 0, 32'h0004_0000));
        send_triangle(corners(0, 0, 1, 0, 0, 1));

        // Random, slow sender, heavily stalled receiver
        tx_idle_pct = 26;
        rx_idle_pct = 84;
        load_elastic($urandom, $urandom_range(0, 32767), 32'd0);
        random_phase(28, 1'b1);

        // Random, sluggish sender, lightly stalled receiver
        tx_idle_pct = 84;
        rx_idle_pct = 26;
        load_elastic($urandom_range(1, 200000), $urandom_range(0, 32767), 32'd1);
        random_phase(28, 1'b0);

        // Random, both sides at full speed
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_elastic($urandom, $urandom_range(16000, 32767), $urandom_range(1));
        random_phase(28, 1'b0);

        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (entries_pending == 0);
        repeat (SETTLE_WAIT) @(posedge clk);

        $display("covered %0d triangles (%0d with a repeated corner), %0d entries checked",
                 req_count, degen_count, entries_seen);
        $display("both plane modes, modulus and Poisson extremes, three throttle phases");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
